// ===== sv/t8u16_pkg.sv =====
// Shared types and constants for the tagged UTF-8 to UTF-16 decoder.
`default_nettype none
package t8u16_pkg;

   localparam int UNIT_W = 16;

   localparam logic [7:0] TAG_BYTE     = 8'hFF;
   localparam logic [7:0] ASCII_MASK   = 8'h80;
   localparam logic [7:0] LEAD2_MASK   = 8'hE0;
   localparam logic [7:0] LEAD2_CODE   = 8'hC0;
   localparam logic [7:0] LEAD3_MASK   = 8'hF0;
   localparam logic [7:0] LEAD3_CODE   = 8'hE0;
   localparam logic [7:0] LEAD4_MASK   = 8'hF8;
   localparam logic [7:0] LEAD4_CODE   = 8'hF0;
   localparam logic [7:0] LEAD2_PAYLD  = 8'h1F;
   localparam logic [7:0] LEAD3_PAYLD  = 8'h0F;
   localparam logic [7:0] CONT_PAYLD   = 8'h3F;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   typedef struct packed {
      logic [1:0]        bytes_pending;
      logic [UNIT_W-1:0] partial_value;
      logic              four_byte_seq;
   } dec_state_type;

   typedef struct packed {
      logic              has_unit;
      logic [UNIT_W-1:0] utf16_unit;
      logic              end_marker;
   } dec_result_type;

endpackage
`default_nettype wire

// ===== sv/t8u16_core.sv =====
// Decoder state registers and the per-beat decode step.
`default_nettype none
module t8u16_core
   import t8u16_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [UNIT_W-1:0] code_unit,
   input  wire logic              string_end,
   output dec_result_type         result
);

   dec_state_type state_ff;
   dec_state_type state_in;

   logic [7:0] low_byte;
   logic [1:0] pend_dec;
   logic [UNIT_W-1:0] shifted;

   assign low_byte = code_unit[7:0];
   assign pend_dec = state_ff.bytes_pending - 2'd1;
   assign shifted  = {state_ff.partial_value[UNIT_W-7:0], low_byte[5:0] & CONT_PAYLD[5:0]};

   always_comb begin
      state_in          = state_ff;
      result.has_unit   = 1'b0;
      result.utf16_unit = '0;
      result.end_marker = string_end;
      if (state_ff.bytes_pending != PEND_NONE) begin
         state_in.partial_value = shifted;
         state_in.bytes_pending = pend_dec;
         if (pend_dec == PEND_NONE) begin
            result.has_unit   = 1'b1;
            result.utf16_unit = state_ff.four_byte_seq ? '0 : shifted;
            state_in.partial_value = '0;
            state_in.four_byte_seq = 1'b0;
         end
      end else if (code_unit[15:8] == TAG_BYTE) begin
         if ((low_byte & ASCII_MASK) == 8'h00) begin
            result.has_unit   = 1'b1;
            result.utf16_unit = {8'h00, low_byte};
         end else if ((low_byte & LEAD2_MASK) == LEAD2_CODE) begin
            state_in.bytes_pending = PEND_ONE;
            state_in.partial_value = {8'h00, low_byte & LEAD2_PAYLD};
            state_in.four_byte_seq = 1'b0;
         end else if ((low_byte & LEAD3_MASK) == LEAD3_CODE) begin
            state_in.bytes_pending = PEND_TWO;
            state_in.partial_value = {8'h00, low_byte & LEAD3_PAYLD};
            state_in.four_byte_seq = 1'b0;
         end else if ((low_byte & LEAD4_MASK) == LEAD4_CODE) begin
            state_in.bytes_pending = PEND_THREE;
            state_in.partial_value = '0;
            state_in.four_byte_seq = 1'b1;
         end
      end else begin
         result.has_unit   = 1'b1;
         result.utf16_unit = code_unit;
      end
      if (string_end) begin
         state_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/tagged_utf8_to_utf16_decoder.sv =====
// Top level: input register, decode step and result register.
// Two register stages: a req beat enters the input register, then the result register.
// Throughput: one beat per cycle while rsp accepts; the decoder state loop holds one register.
// Backpressure on rsp stalls the input register, which stalls req.
// Reset is synchronous: both stages empty and decoder state cleared.
`default_nettype none
module tagged_utf8_to_utf16_decoder
   import t8u16_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [UNIT_W-1:0] req_tdata,   // [15:0] code_unit
   input  wire logic              req_tlast,   // string_end
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [UNIT_W-1:0]      rsp_tdata,   // [15:0] utf16_unit
   output logic                   rsp_tuser,   // [0] has_unit
   output logic                   rsp_tlast    // end_marker
);

   logic              in_valid_ff;
   logic [UNIT_W-1:0] in_unit_ff;
   logic              in_last_ff;
   logic              out_valid_ff;
   dec_result_type    out_ff;
   dec_result_type    result;
   logic              out_free;
   logic              advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   t8u16_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .code_unit  (in_unit_ff),
      .string_end (in_last_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_unit_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.utf16_unit;
   assign rsp_tuser  = out_ff.has_unit;
   assign rsp_tlast  = out_ff.end_marker;

endmodule
`default_nettype wire

// ===== sv/t8u16_checker.sv =====
// Port-level checker for the decoder, bound to the top level.
`default_nettype none
module t8u16_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_no_unit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'h0000)
      else $error("nonzero unit on a beat without a unit");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled while rsp is empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

endmodule

bind tagged_utf8_to_utf16_decoder t8u16_checker u_t8u16_checker (.*);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for the tagged UTF-8 to UTF-16 decoder: stream stimulus and result check.
`timescale 1ns / 1ps
module tb;
   import t8u16_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 12;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [UNIT_W-1:0] req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [UNIT_W-1:0] rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;

   // decoder state as the bench tracks it
   logic [1:0]        cont_left = PEND_NONE;
   logic [UNIT_W-1:0] code_acc = '0;
   logic              quad_seq = 1'b0;

   dec_result_type    expected_units[$];
   dec_result_type    oldest_unit;
   int                mismatch_count = 0;
   int                stall_cycles = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;

   tagged_utf8_to_utf16_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic dec_result_type decode_unit(logic [UNIT_W-1:0] unit, logic last);
      dec_result_type r;
      logic [7:0]     lo;
      lo = unit[7:0];
      r = '0;
      r.end_marker = last;
      if (cont_left != PEND_NONE) begin
         code_acc = {code_acc[9:0], lo[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == PEND_NONE) begin
            r.has_unit = 1'b1;
            r.utf16_unit = quad_seq ? '0 : code_acc;
            code_acc = '0;
            quad_seq = 1'b0;
         end
      end else if (unit[15:8] == TAG_BYTE) begin
         if ((lo & ASCII_MASK) == 8'h00) begin
            r.has_unit = 1'b1;
            r.utf16_unit = {8'h00, lo};
         end else if ((lo & LEAD2_MASK) == LEAD2_CODE) begin
            cont_left = PEND_ONE;
            code_acc = {8'h00, lo & LEAD2_PAYLD};
            quad_seq = 1'b0;
         end else if ((lo & LEAD3_MASK) == LEAD3_CODE) begin
            cont_left = PEND_TWO;
            code_acc = {8'h00, lo & LEAD3_PAYLD};
            quad_seq = 1'b0;
         end else if ((lo & LEAD4_MASK) == LEAD4_CODE) begin
            cont_left = PEND_THREE;
            code_acc = '0;
            quad_seq = 1'b1;
         end
      end else begin
         r.has_unit = 1'b1;
         r.utf16_unit = unit;
      end
      if (last) begin
         cont_left = PEND_NONE;
         code_acc = '0;
         quad_seq = 1'b0;
      end
      return r;
   endfunction

   // one beat on req, with random idle cycles ahead of it
   task automatic send_unit(logic [UNIT_W-1:0] unit, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= unit;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_units.push_back(decode_unit(unit, last));
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
   endtask

   function automatic logic [UNIT_W-1:0] cont_unit();
      if ($urandom_range(99) < 85)
         return {TAG_BYTE, 2'b10, 6'($urandom_range(63))};
      return UNIT_W'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic random_end();
      return $urandom_range(15) == 0;
   endfunction

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_units.size() == 0) begin
            $error("result beat with nothing expected: data 0x%0h", rsp_tdata);
            mismatch_count++;
         end else begin
            oldest_unit = expected_units.pop_front();
            check_field("has_unit", int'(oldest_unit.has_unit), int'(rsp_tuser));
            check_field("utf16_unit", int'(oldest_unit.utf16_unit), int'(rsp_tdata));
            check_field("end_marker", int'(oldest_unit.end_marker), int'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic test_directed();
      send_unit(16'h0000, 1'b0);
      send_unit(16'hFEFF, 1'b0);
      send_unit(16'h7FFF, 1'b0);
      send_unit(16'hFF00, 1'b0);
      send_unit(16'hFF7F, 1'b1);
      send_unit(16'hFFC3, 1'b0);          // two-byte sequence
      send_unit(16'hFFA9, 1'b0);
      send_unit(16'hFFC2, 1'b0);          // untagged unit as continuation
      send_unit(16'h12F4, 1'b0);
      send_unit(16'hFFE2, 1'b0);          // three-byte sequence
      send_unit(16'hFF82, 1'b0);
      send_unit(16'hFFAC, 1'b0);
      send_unit(16'hFFF0, 1'b0);          // four-byte sequence yields zero
      send_unit(16'hFF9F, 1'b0);
      send_unit(16'hFF98, 1'b0);
      send_unit(16'hFFBF, 1'b0);
      send_unit(16'hFF80, 1'b0);          // invalid leads
      send_unit(16'hFFF8, 1'b0);
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'hFFEF, 1'b0);          // truncated by end of string
      send_unit(16'hFFBF, 1'b1);
      send_unit(16'hFF41, 1'b0);
      send_unit(16'hFFDF, 1'b1);          // lead on last unit
      send_unit(16'hFFC0, 1'b0);
      send_unit(16'hFFFF, 1'b1);          // continuation with all ones, end of string
   endtask

   task automatic test_pause_mid_sequence();
      send_unit(16'hFFE4, 1'b0);
      wait_results_drained();
      send_unit(16'hFFB8, 1'b0);
      wait_results_drained();
      send_unit(16'hFF80, 1'b0);
      send_unit(16'hFFF4, 1'b0);
      wait_results_drained();
      send_unit(16'hFF8F, 1'b0);
      send_unit(16'hFFBF, 1'b0);
      send_unit(16'hFFBF, 1'b1);
   endtask

   task automatic test_random_text(int n_units);
      int sent;
      int kind;
      int n_cont;
      sent = 0;
      while (sent < n_units) begin
         kind = $urandom_range(99);
         n_cont = 0;
         if (kind < 15) begin
            send_unit(UNIT_W'($urandom_range(16'hFFFF)), random_end());
         end else if (kind < 30) begin
            send_unit({TAG_BYTE, 1'b0, 7'($urandom_range(127))}, random_end());
         end else if (kind < 50) begin
            send_unit({TAG_BYTE, 3'b110, 5'($urandom_range(31))}, random_end());
            n_cont = 1;
         end else if (kind < 70) begin
            send_unit({TAG_BYTE, 4'b1110, 4'($urandom_range(15))}, random_end());
            n_cont = 2;
         end else if (kind < 82) begin
            send_unit({TAG_BYTE, 5'b11110, 3'($urandom_range(7))}, random_end());
            n_cont = 3;
         end else if (kind < 90) begin
            if ($urandom_range(1))
               send_unit({TAG_BYTE, 2'b10, 6'($urandom_range(63))}, random_end());
            else
               send_unit({TAG_BYTE, 5'b11111, 3'($urandom_range(7))}, random_end());
         end else begin
            send_unit({TAG_BYTE, 8'($urandom_range(255))}, random_end());
         end
         sent += 1 + n_cont;
         repeat (n_cont) send_unit(cont_unit(), random_end());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 51;
      test_directed();
      test_random_text(590);

      send_idle_pct = 51;
      recv_idle_pct = 11;
      test_pause_mid_sequence();
      test_random_text(590);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_text(590);

      req_tvalid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
